@@ rtl/drp_pkg.sv @@
// ----------------------------------------------------------------------------
// drp_pkg
// Shared types and constants for the DHCP request parser.
// ----------------------------------------------------------------------------
package drp_pkg;

  localparam int unsigned MAX_LEN = 1024;
  localparam int unsigned POS_W = 11;
  localparam logic [POS_W-1:0] POS_SAT = '1;

  localparam logic [7:0] OPT_PAD = 8'd0;
  localparam logic [7:0] OPT_END = 8'd255;
  localparam logic [7:0] OPT_TYPE = 8'd53;
  localparam logic [7:0] OPT_REQ = 8'd50;
  localparam logic [7:0] OPT_SRV = 8'd54;
  localparam logic [7:0] OPT_OVL = 8'd52;
  localparam logic [31:0] COOKIE = 32'h63825363;
  localparam logic [7:0] HLEN_ETH = 8'd6;
  localparam logic [7:0] TYPE_DISCOVER = 8'd1;
  localparam logic [7:0] TYPE_REQUEST = 8'd3;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_CODE   = 5'b00010,
    PH_LEN    = 5'b00100,
    PH_DATA   = 5'b01000,
    PH_ENDED  = 5'b10000
  } phase_t;

  // word passed from front to back: one byte with its last flag and position
  typedef struct packed {
    logic [7:0]       data;
    logic             last;
    logic [POS_W-1:0] pos;
  } fe_word_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  msg_type;
    logic [47:0] client_mac;
    logic [31:0] transaction_id;
    logic [31:0] client_ip;
    logic [31:0] requested_ip;
    logic        requested_present;
    logic [31:0] server_ip;
    logic        server_present;
  } result_t;

endpackage

@@ rtl/dhcp_request_parser.sv @@
// ----------------------------------------------------------------------------
// dhcp_request_parser
// Checks a DHCP message byte stream and extracts client fields.
// ----------------------------------------------------------------------------
// Input: valid/stall with data_byte and last_byte, one message byte per word.
// Output: valid/stall, one result word per message, raised after its last
// byte: accepted plus extracted fields, or all zeros on reject.
// A front stage numbers the bytes and feeds a two-word queue; the back stage
// parses one byte per cycle from the queue unless stalled, and registers the result.
// Throughput: one byte per cycle sustained unless a held result stalls.
// The last byte is queued before it is parsed; its pop registers the result.
// When the receiver stalls, a finished result is held; the back stage keeps
// parsing the next message and stops only at that message's last byte,
// after which the queue fills and stall rises on the input.
// Reset (rst, synchronous) empties the queue, drops out_valid and returns
// the parser to the header phase.
// ----------------------------------------------------------------------------
module dhcp_request_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        accepted,
  output logic [1:0]  msg_type,
  output logic [47:0] client_mac,
  output logic [31:0] transaction_id,
  output logic [31:0] client_ip,
  output logic [31:0] requested_ip,
  output logic        requested_present,
  output logic [31:0] server_ip,
  output logic        server_present
);
  import drp_pkg::*;

  logic     q_valid;
  logic     q_pop;
  fe_word_t q_word;
  result_t  res;

  drp_front u_front (
    .clk(clk), .rst(rst), .valid(in_valid), .stall(in_stall),
    .data_byte(data_byte), .last_byte(last_byte),
    .q_valid(q_valid), .q_pop(q_pop), .q_word(q_word)
  );

  drp_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(q_pop), .q_word(q_word),
    .out_valid(out_valid), .out_stall(out_stall), .res(res)
  );

  assign accepted = res.accepted;
  assign msg_type = res.msg_type;
  assign client_mac = res.client_mac;
  assign transaction_id = res.transaction_id;
  assign client_ip = res.client_ip;
  assign requested_ip = res.requested_ip;
  assign requested_present = res.requested_present;
  assign server_ip = res.server_ip;
  assign server_present = res.server_present;

endmodule

@@ rtl/drp_front.sv @@
// ----------------------------------------------------------------------------
// drp_front
// Accepts bytes, tags each with its position, and queues them (2 deep).
// ----------------------------------------------------------------------------
module drp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid,
  output logic                stall,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output logic                q_valid,
  input  logic                q_pop,
  output drp_pkg::fe_word_t   q_word
);
  import drp_pkg::*;

  logic [POS_W-1:0] pos;
  fe_word_t         mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  fe_word_t         w;

  assign stall = (count == 2'd2);
  assign push = valid && !stall;
  assign q_valid = (count != 2'd0);
  assign q_word = mem[rd_ptr];

  always_comb begin
    w.data = data_byte;
    w.last = last_byte;
    w.pos = pos;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
        if (last_byte) begin
          pos <= '0;
        end else if (pos != POS_SAT) begin
          pos <= pos + 1'b1;
        end
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> count != 2'd0) else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("bad count");

endmodule

@@ rtl/drp_back.sv @@
// ----------------------------------------------------------------------------
// drp_back
// Parses queued bytes and holds one result in an output register.
// ----------------------------------------------------------------------------
module drp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_pop,
  input  drp_pkg::fe_word_t   q_word,
  output logic                out_valid,
  input  logic                out_stall,
  output drp_pkg::result_t    res
);
  import drp_pkg::*;

  phase_t      phase, phase_next;
  logic        rej, rej_next;
  logic [7:0]  code, code_next;
  logic [7:0]  remain, remain_next;
  logic [47:0] mac, mac_next;
  logic [31:0] xid, xid_next;
  logic [31:0] ciaddr, ciaddr_next;
  logic [7:0]  mtype, mtype_next;
  logic [31:0] reqip, reqip_next;
  logic [31:0] srvip, srvip_next;
  logic [1:0]  seen, seen_next;
  logic        bad;
  logic [7:0]  b;
  logic [POS_W-1:0] p;
  logic        ok;
  result_t     r;

  assign q_pop = q_valid && (!out_valid || !out_stall || !q_word.last);
  assign b = q_word.data;
  assign p = q_word.pos;

  always_comb begin
    phase_next = phase;
    rej_next = rej;
    code_next = code;
    remain_next = remain;
    mac_next = mac;
    xid_next = xid;
    ciaddr_next = ciaddr;
    mtype_next = mtype;
    reqip_next = reqip;
    srvip_next = srvip;
    seen_next = seen;
    bad = 1'b0;
    if (p >= POS_W'(MAX_LEN)) begin
      rej_next = 1'b1;
    end
    if (!rej_next) begin
      case (phase)
        PH_HEADER: begin
          if (p <= POS_W'(1)) begin
            bad = (b != 8'd1);
          end else if (p == POS_W'(2)) begin
            bad = (b != HLEN_ETH);
          end else if (p == POS_W'(3)) begin
            bad = (b != 8'd0);
          end else if (p >= POS_W'(4) && p <= POS_W'(7)) begin
            xid_next = {xid[23:0], b};
          end else if (p >= POS_W'(12) && p <= POS_W'(15)) begin
            ciaddr_next = {ciaddr[23:0], b};
          end else if (p >= POS_W'(24) && p <= POS_W'(27)) begin
            bad = (b != 8'd0);
          end else if (p >= POS_W'(28) && p <= POS_W'(33)) begin
            mac_next = {mac[39:0], b};
            if (p == POS_W'(28) && b[0]) begin
              bad = 1'b1;
            end
            if (p == POS_W'(33) && mac_next == 48'd0) begin
              bad = 1'b1;
            end
          end else if (p >= POS_W'(236) && p <= POS_W'(239)) begin
            bad = (b != COOKIE[8*(3-(p[1:0]))+:8]);
          end
          if (p == POS_W'(239)) begin
            phase_next = PH_CODE;
          end
          if (bad) begin
            rej_next = 1'b1;
          end
        end
        PH_CODE: begin
          if (b == OPT_END) begin
            phase_next = PH_ENDED;
          end else if (b != OPT_PAD) begin
            code_next = b;
            phase_next = PH_LEN;
          end
        end
        PH_LEN: begin
          if (code == OPT_TYPE) begin
            bad = (b != 8'd1) || (mtype != 8'd0);
          end else if (code == OPT_REQ) begin
            bad = (b != 8'd4) || seen[0];
            seen_next[0] = 1'b1;
          end else if (code == OPT_SRV) begin
            bad = (b != 8'd4) || seen[1];
            seen_next[1] = 1'b1;
          end else if (code == OPT_OVL) begin
            bad = 1'b1;
          end
          if (bad) begin
            rej_next = 1'b1;
          end else begin
            remain_next = b;
            phase_next = (b == 8'd0) ? PH_CODE : PH_DATA;
          end
        end
        PH_DATA: begin
          if (code == OPT_TYPE) begin
            mtype_next = b;
          end else if (code == OPT_REQ) begin
            reqip_next = {reqip[23:0], b};
          end else if (code == OPT_SRV) begin
            srvip_next = {srvip[23:0], b};
          end
          remain_next = remain - 8'd1;
          if (remain_next == 8'd0) begin
            phase_next = PH_CODE;
          end
        end
        PH_ENDED: begin
        end
        default: begin
          phase_next = PH_HEADER;
        end
      endcase
    end
    ok = !rej_next && (phase_next == PH_ENDED) &&
         (mtype_next == TYPE_DISCOVER || mtype_next == TYPE_REQUEST);
    r = '0;
    if (ok) begin
      r.accepted = 1'b1;
      r.msg_type = mtype_next[1:0];
      r.client_mac = mac_next;
      r.transaction_id = xid_next;
      r.client_ip = ciaddr_next;
      r.requested_ip = seen_next[0] ? reqip_next : 32'd0;
      r.requested_present = seen_next[0];
      r.server_ip = seen_next[1] ? srvip_next : 32'd0;
      r.server_present = seen_next[1];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_word.last) begin
      res <= r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (q_pop && q_word.last)) begin
      phase <= PH_HEADER;
      rej <= 1'b0;
      code <= '0;
      remain <= '0;
      mac <= '0;
      xid <= '0;
      ciaddr <= '0;
      mtype <= '0;
      reqip <= '0;
      srvip <= '0;
      seen <= '0;
    end else if (q_pop) begin
      phase <= phase_next;
      rej <= rej_next;
      code <= code_next;
      remain <= remain_next;
      mac <= mac_next;
      xid <= xid_next;
      ciaddr <= ciaddr_next;
      mtype <= mtype_next;
      reqip <= reqip_next;
      srvip <= srvip_next;
      seen <= seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && q_word.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !(q_pop && q_word.last))
    else $error("result overwritten");
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !res.accepted |-> res.msg_type == 2'd0 && !res.server_present)
    else $error("reject not zeroed");
  a_type_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.accepted |-> res.msg_type == 2'd1 || res.msg_type == 2'd3)
    else $error("bad type");

endmodule
